FILE: rtl/core/abff_pkg.sv
package abff_pkg;

  localparam int WORD_W      = 128;
  localparam int POS_W       = $clog2(WORD_W);
  localparam int IDX_W       = 12;
  localparam int LIMIT_W     = 13;
  localparam int WIDX_W      = IDX_W - POS_W;
  localparam int INDEX_SPAN  = 4096;
  localparam int ENTRIES_DEF = 4096;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FIND  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_FIND,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } search_t;

endpackage

FILE: rtl/core/abff_if.sv
interface abff_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [abff_pkg::IDX_W-1:0] entry_index;
  logic                       new_value;

  modport source (output valid, mode, entry_index, new_value, input ready);
  modport sink   (input valid, mode, entry_index, new_value, output ready);
endinterface

interface abff_out_if;
  logic                       valid;
  logic                       ready;
  logic                       bit_status;
  logic [abff_pkg::IDX_W-1:0] free_index;
  logic                       found;
  logic                       index_error;

  modport source (output valid, bit_status, free_index, found, index_error, input ready);
  modport sink   (input valid, bit_status, free_index, found, index_error, output ready);
endinterface

FILE: rtl/core/abff_ram.sv
module abff_ram #(
  parameter int WIDTH = abff_pkg::WORD_W,
  parameter int DEPTH = abff_pkg::INDEX_SPAN / abff_pkg::WORD_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/abff_word_search.sv
module abff_word_search (
  input  logic [abff_pkg::WORD_W-1:0] word_i,
  input  logic [abff_pkg::POS_W-1:0]  top_i,
  output abff_pkg::search_t           res_o
);

  // lowest clear bit at or below top_i
  always_comb begin
    res_o = '0;
    for (int b = abff_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!word_i[b] && (abff_pkg::POS_W'(b) <= top_i)) begin
        res_o.hit = 1'b1;
        res_o.pos = abff_pkg::POS_W'(b);
      end
    end
  end

endmodule

FILE: rtl/core/allocation_bitmap_first_free_unit.sv
// First-fit allocation bitmap, one mark bit per entry (1 allocated, 0 free),
// held as 128-bit words in a single-port-read RAM with a per-word valid flag
// so that the whole map reads as free straight after reset, with no clearing
// pass. Write takes one read-modify-write of the addressed word; check only
// reads that word. Find reads one word per cycle from word 0 upward and
// stops at the first word holding a free entry below the limit, or after the
// last word below the limit with found low. Out-of-range indices, a zero
// limit and the unused mode answer without reading the RAM. One item is
// worked on at a time; a finished result sits in the output register and the
// next input beat is taken while it waits. The user must write the entry
// limit only while the unit is idle; the unit itself does not enforce this.
module allocation_bitmap_first_free_unit #(
  parameter int ENTRIES = abff_pkg::ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  abff_in_if.sink                      in_i,
  abff_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [abff_pkg::LIMIT_W-1:0] cfg_data_i
);

  // entries that an index can reach
  localparam int SPAN  = (ENTRIES < abff_pkg::INDEX_SPAN) ? ENTRIES : abff_pkg::INDEX_SPAN;
  localparam int DEPTH = (SPAN + abff_pkg::WORD_W - 1) / abff_pkg::WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [abff_pkg::LIMIT_W-1:0] SPAN_L = abff_pkg::LIMIT_W'(SPAN);

  abff_pkg::state_e state_q, state_d;

  logic [abff_pkg::LIMIT_W-1:0] entry_limit_q;

  // per-word valid flags, a word never written reads as all free
  logic [DEPTH-1:0] row_valid_q, row_valid_d;

  // item in progress
  logic                        is_write_q, is_write_d;
  logic                        new_value_q, new_value_d;
  logic [abff_pkg::IDX_W-1:0]  idx_q, idx_d;

  // scan counters: next word to read, word being examined
  logic [abff_pkg::WIDX_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [abff_pkg::WIDX_W-1:0] ev_q, ev_d;

  // result waiting for the output register
  logic                        res_bit_q, res_bit_d;
  logic [abff_pkg::IDX_W-1:0]  res_idx_q, res_idx_d;
  logic                        res_found_q, res_found_d;
  logic                        res_err_q, res_err_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_bit_q, out_bit_d;
  logic [abff_pkg::IDX_W-1:0]  out_idx_q, out_idx_d;
  logic                        out_found_q, out_found_d;
  logic                        out_err_q, out_err_d;

  // ram port signals
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [abff_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  // active limit and its last word and bit
  logic [abff_pkg::LIMIT_W-1:0] lim, lim_m1;
  logic [abff_pkg::WIDX_W-1:0]  last_word;
  logic [abff_pkg::POS_W-1:0]   last_pos;

  logic                         accept;
  logic [AW-1:0]                rmw_row, ev_row;
  logic [abff_pkg::WORD_W-1:0]  rmw_word, ev_word;
  logic [abff_pkg::POS_W-1:0]   search_top;
  abff_pkg::search_t            search;

  assign lim       = (entry_limit_q > SPAN_L) ? SPAN_L : entry_limit_q;
  assign lim_m1    = lim - abff_pkg::LIMIT_W'(1);
  assign last_word = lim_m1[abff_pkg::IDX_W-1:abff_pkg::POS_W];
  assign last_pos  = lim_m1[abff_pkg::POS_W-1:0];

  assign in_i.ready = (state_q == abff_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign rmw_row  = AW'(idx_q[abff_pkg::IDX_W-1:abff_pkg::POS_W]);
  assign ev_row   = AW'(ev_q);
  assign rmw_word = row_valid_q[rmw_row] ? ram_rdata : '0;
  assign ev_word  = row_valid_q[ev_row] ? ram_rdata : '0;

  // only the last word is cut short by the limit
  assign search_top = (ev_q == last_word) ? last_pos : '1;

  abff_ram #(
    .WIDTH (abff_pkg::WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  abff_word_search u_search (
    .word_i (ev_word),
    .top_i  (search_top),
    .res_o  (search)
  );

  always_comb begin
    state_d      = state_q;
    row_valid_d  = row_valid_q;
    is_write_d   = is_write_q;
    new_value_d  = new_value_q;
    idx_d        = idx_q;
    rd_cnt_d     = rd_cnt_q;
    ev_d         = ev_q;
    res_bit_d    = res_bit_q;
    res_idx_d    = res_idx_q;
    res_found_d  = res_found_q;
    res_err_d    = res_err_q;
    out_valid_d  = out_valid_q;
    out_bit_d    = out_bit_q;
    out_idx_d    = out_idx_q;
    out_found_d  = out_found_q;
    out_err_d    = out_err_q;
    ram_we       = 1'b0;
    ram_waddr    = rmw_row;
    ram_wdata    = rmw_word;
    ram_re       = 1'b0;
    ram_raddr    = AW'(rd_cnt_q);

    // output beat taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      abff_pkg::ST_IDLE: begin
        if (accept) begin
          is_write_d  = (in_i.mode == abff_pkg::MODE_WRITE);
          new_value_d = in_i.new_value;
          idx_d       = in_i.entry_index;
          res_bit_d   = 1'b0;
          res_idx_d   = '0;
          res_found_d = 1'b0;
          res_err_d   = 1'b0;
          case (in_i.mode)
            abff_pkg::MODE_CHECK, abff_pkg::MODE_WRITE: begin
              if ({1'b0, in_i.entry_index} < lim) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_i.entry_index[abff_pkg::IDX_W-1:abff_pkg::POS_W]);
                state_d   = abff_pkg::ST_RMW;
              end else begin
                res_err_d = 1'b1;
                state_d   = abff_pkg::ST_RESP;
              end
            end
            abff_pkg::MODE_FIND: begin
              if (lim != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_cnt_d  = abff_pkg::WIDX_W'(1);
                ev_d      = '0;
                state_d   = abff_pkg::ST_FIND;
              end else begin
                state_d   = abff_pkg::ST_RESP;
              end
            end
            default: begin
              // unused mode: all-zero answer
              state_d = abff_pkg::ST_RESP;
            end
          endcase
        end
      end

      abff_pkg::ST_RMW: begin
        if (is_write_q) begin
          ram_we                = 1'b1;
          ram_wdata             = rmw_word;
          ram_wdata[idx_q[abff_pkg::POS_W-1:0]] = new_value_q;
          row_valid_d[rmw_row]  = 1'b1;
          res_bit_d             = new_value_q;
        end else begin
          res_bit_d = rmw_word[idx_q[abff_pkg::POS_W-1:0]];
        end
        state_d = abff_pkg::ST_RESP;
      end

      abff_pkg::ST_FIND: begin
        // keep one word read ahead of the one examined
        if (rd_cnt_q <= last_word) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + abff_pkg::WIDX_W'(1);
        end
        if (search.hit) begin
          res_found_d = 1'b1;
          res_idx_d   = {ev_q, search.pos};
          state_d     = abff_pkg::ST_RESP;
        end else if (ev_q == last_word) begin
          state_d     = abff_pkg::ST_RESP;
        end else begin
          ev_d        = ev_q + abff_pkg::WIDX_W'(1);
        end
      end

      abff_pkg::ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_bit_q;
          out_idx_d   = res_idx_q;
          out_found_d = res_found_q;
          out_err_d   = res_err_q;
          state_d     = abff_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = abff_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= abff_pkg::ST_IDLE;
      entry_limit_q <= abff_pkg::LIMIT_RESET;
      row_valid_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        entry_limit_q <= cfg_data_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    is_write_q  <= is_write_d;
    new_value_q <= new_value_d;
    idx_q       <= idx_d;
    rd_cnt_q    <= rd_cnt_d;
    ev_q        <= ev_d;
    res_bit_q   <= res_bit_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    res_err_q   <= res_err_d;
    out_bit_q   <= out_bit_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_err_q   <= out_err_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.bit_status  = out_bit_q;
  assign out_o.free_index  = out_idx_q;
  assign out_o.found       = out_found_q;
  assign out_o.index_error = out_err_q;

endmodule
